### rtl/core/tbpc_pkg.sv
`default_nettype none

package tbpc_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned LIMIT_W   = 16;
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 8;
    localparam logic [LIMIT_W-1:0] LONG_PRESS_RESET = 16'd1000;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_A_SHORT = 3'd1,
        EV_A_LONG  = 3'd2,
        EV_B_SHORT = 3'd3,
        EV_B_LONG  = 3'd4,
        EV_COMBO   = 3'd5
    } t_event_code;

    // what one button lane found for the current poll
    typedef struct packed {
        logic fired;
        logic is_long;
    } t_lane_res;

endpackage

`default_nettype wire

### rtl/core/tbpc_lane.sv
`default_nettype none

module tbpc_lane
    import tbpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic               i_combo,
    input  wire logic               i_down,
    input  wire logic [TIME_W-1:0]  i_now_ms,
    input  wire logic [LIMIT_W-1:0] i_long_press_ms,
    output t_lane_res               o_res
);

    logic              r_held, n_held;
    logic              r_reported, n_reported;
    logic [TIME_W-1:0] r_press_time, n_press_time;
    logic [TIME_W-1:0] span;
    logic              over_limit;

    assign span       = i_now_ms - r_press_time;
    assign over_limit = span >= {{(TIME_W-LIMIT_W){1'b0}}, i_long_press_ms};

    always_comb begin
        n_held       = r_held;
        n_reported   = r_reported;
        n_press_time = r_press_time;
        o_res        = '0;
        if (i_combo) begin
            // combo poll only marks the press as handled
            n_reported = 1'b1;
        end else if (i_down && !r_held) begin
            n_held       = 1'b1;
            n_press_time = i_now_ms;
            n_reported   = 1'b0;
        end else if (!i_down && r_held) begin
            n_held = 1'b0;
            if (!r_reported) begin
                o_res.fired   = 1'b1;
                o_res.is_long = over_limit;
            end
        end else if (i_down && r_held && !r_reported && over_limit) begin
            n_reported    = 1'b1;
            o_res.fired   = 1'b1;
            o_res.is_long = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= 1'b0;
            r_reported   <= 1'b0;
            r_press_time <= '0;
        end else if (i_accept) begin
            r_held       <= n_held;
            r_reported   <= n_reported;
            r_press_time <= n_press_time;
        end
    end

endmodule

`default_nettype wire

### rtl/core/tbpc_merge.sv
`default_nettype none

module tbpc_merge
    import tbpc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_accept,
    input  wire logic      i_combo,
    input  wire t_lane_res i_res_a,
    input  wire t_lane_res i_res_b,
    input  wire logic      i_m_ready,
    output logic           o_ready,
    output logic           o_valid,
    output t_event_code    o_code
);

    logic        r_valid;
    t_event_code r_code, n_code;

    // output register frees up in the same cycle it is drained
    assign o_ready = !r_valid || i_m_ready;
    assign o_valid = r_valid;
    assign o_code  = r_code;

    always_comb begin
        // b wins when both lanes fire
        priority if (i_combo) begin
            n_code = EV_COMBO;
        end else if (i_res_b.fired) begin
            n_code = i_res_b.is_long ? EV_B_LONG : EV_B_SHORT;
        end else if (i_res_a.fired) begin
            n_code = i_res_a.is_long ? EV_A_LONG : EV_A_SHORT;
        end else begin
            n_code = EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_code <= n_code;
        end
    end

endmodule

`default_nettype wire

### rtl/core/two_button_press_classifier_top.sv
// two-button press classifier
// input stream: one transaction per poll on i_s_tdata; bit 0 is button a level,
// bit 1 button b level, bits 33:2 a free-running millisecond timestamp.
// output stream: one transaction per poll, event code in o_m_tdata[2:0]
// (none, a short, a long, b short, b long, combo).
// i_cfg_we with i_cfg_wdata sets the long-press limit in ms; write only while idle.
// the result is held in the output register from the cycle after the input
// transaction. throughput is one poll per cycle while the receiver does not stall,
// set by the single subtract and compare in each button lane.
// a new poll is taken while the output register holds a result as long as the
// receiver drains it in that cycle; when the receiver stalls, o_s_tready drops
// and the held result stays unchanged.
// reset clears the press state of both buttons, empties the output register and
// sets the limit to 1000 ms.
`default_nettype none

module two_button_press_classifier_top
    import tbpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [LIMIT_W-1:0]   i_cfg_wdata,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // button_a_down[0], button_b_down[1], now_ms[33:2], zero fill
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // event_code[2:0], zero fill
    output logic [M_TDATA_W-1:0]      o_m_tdata
);

    logic [LIMIT_W-1:0] r_long_press_ms;
    logic               accept;
    logic               a_down, b_down, combo;
    logic [TIME_W-1:0]  now_ms;
    t_lane_res          res_a, res_b;
    t_event_code        code;

    assign accept = i_s_tvalid && o_s_tready;
    assign a_down = i_s_tdata[0];
    assign b_down = i_s_tdata[1];
    assign now_ms = i_s_tdata[TIME_W+1:2];
    assign combo  = a_down && b_down;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ms <= LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            r_long_press_ms <= i_cfg_wdata;
        end
    end

    tbpc_lane u_lane_a (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_combo         (combo),
        .i_down          (a_down),
        .i_now_ms        (now_ms),
        .i_long_press_ms (r_long_press_ms),
        .o_res           (res_a)
    );

    tbpc_lane u_lane_b (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_combo         (combo),
        .i_down          (b_down),
        .i_now_ms        (now_ms),
        .i_long_press_ms (r_long_press_ms),
        .o_res           (res_b)
    );

    tbpc_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_combo   (combo),
        .i_res_a   (res_a),
        .i_res_b   (res_b),
        .i_m_ready (i_m_tready),
        .o_ready   (o_s_tready),
        .o_valid   (o_m_tvalid),
        .o_code    (code)
    );

    assign o_m_tdata = {{(M_TDATA_W-3){1'b0}}, code};

    a_combo_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && combo |=> o_m_tvalid && code == EV_COMBO)
        else $error("combo poll did not give combo event");

    a_accept_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_m_tvalid)
        else $error("accepted poll gave no result");

    a_stall_only : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input blocked without output stall");

    a_b_wins : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !combo && res_b.fired |=> code == EV_B_SHORT || code == EV_B_LONG)
        else $error("button b event lost");

endmodule

`default_nettype wire

### tb/two_button_press_classifier_top_tb.sv
`default_nettype none

module two_button_press_classifier_top_tb;
    import tbpc_pkg::*;

    localparam int HOLD_OFF_CYCLES = 60;
    localparam int N_PHASES        = 8;
    localparam int POLLS_PER_PHASE = 78;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [LIMIT_W-1:0]   i_cfg_wdata = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 i_m_tready  = 1'b0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;

    two_button_press_classifier_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // press state of both buttons as the block should see it, index 0 is a, 1 is b
    logic               btn_held [2];
    logic [TIME_W-1:0]  btn_time [2];
    logic               btn_rep  [2];
    logic [LIMIT_W-1:0] limit_ms;

    t_event_code exp_events [$];
    int          events_seen [6];
    int          polls_sent;
    int          n_checked;
    int          n_errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_reqs;
    int          hold_off_seen;
    int          hold_left;
    logic [31:0] tcur;

    typedef struct packed {
        logic              a;
        logic              b;
        logic [TIME_W-1:0] t;
        logic              typed;
        t_event_code       ev;
    } t_press_row;

    // opening polls at the reset limit of 1000 ms
    t_press_row press_script [24] = '{
        '{1'b0, 1'b0, 32'd0,          1'b1, EV_NONE},
        '{1'b1, 1'b0, 32'd100,        1'b0, EV_NONE},
        '{1'b0, 1'b0, 32'd600,        1'b0, EV_NONE},
        '{1'b1, 1'b0, 32'd1000,       1'b0, EV_NONE},
        '{1'b0, 1'b0, 32'd1999,       1'b0, EV_NONE},  // one ms short of the limit
        '{1'b0, 1'b1, 32'd2000,       1'b0, EV_NONE},
        '{1'b0, 1'b1, 32'd2999,       1'b0, EV_NONE},
        '{1'b0, 1'b1, 32'd3000,       1'b0, EV_NONE},  // long while held, exactly at limit
        '{1'b0, 1'b1, 32'd9000,       1'b0, EV_NONE},
        '{1'b0, 1'b0, 32'd9001,       1'b0, EV_NONE},
        '{1'b1, 1'b0, 32'd10000,      1'b0, EV_NONE},
        '{1'b0, 1'b0, 32'd11000,      1'b0, EV_NONE},  // late release with no hold poll
        '{1'b1, 1'b1, 32'd12000,      1'b1, EV_COMBO},
        '{1'b1, 1'b0, 32'd12500,      1'b0, EV_NONE},  // fresh press right after combo
        '{1'b1, 1'b1, 32'd12600,      1'b1, EV_COMBO},
        '{1'b0, 1'b0, 32'd20000,      1'b0, EV_NONE},
        '{1'b1, 1'b0, 32'hFFFF_FF00,  1'b0, EV_NONE},
        '{1'b0, 1'b0, 32'h0000_0100,  1'b0, EV_NONE},  // timestamp wraps forward
        '{1'b0, 1'b1, 32'h0000_1000,  1'b0, EV_NONE},
        '{1'b0, 1'b0, 32'h0000_0FFF,  1'b0, EV_NONE},  // time runs backwards
        '{1'b0, 1'b1, 32'hFFFF_FFFF,  1'b0, EV_NONE},
        '{1'b1, 1'b0, 32'h7FFF_FFFF,  1'b0, EV_NONE},
        '{1'b1, 1'b0, 32'h7FFF_FFFF,  1'b0, EV_NONE},
        '{1'b0, 1'b0, 32'h0000_0000,  1'b0, EV_NONE}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_event_code lane_step(input int k, input logic down,
                                              input logic [TIME_W-1:0] t,
                                              input t_event_code ev_short,
                                              input t_event_code ev_long);
        t_event_code       ev;
        logic [TIME_W-1:0] span;
        ev   = EV_NONE;
        span = t - btn_time[k];
        if (down && !btn_held[k]) begin
            btn_held[k] = 1'b1;
            btn_time[k] = t;
            btn_rep[k]  = 1'b0;
        end else if (!down && btn_held[k]) begin
            btn_held[k] = 1'b0;
            if (!btn_rep[k])
                ev = (span >= TIME_W'(limit_ms)) ? ev_long : ev_short;
        end else if (down && btn_held[k] && !btn_rep[k]) begin
            if (span >= TIME_W'(limit_ms)) begin
                btn_rep[k] = 1'b1;
                ev         = ev_long;
            end
        end
        return ev;
    endfunction

    function automatic t_event_code classify_poll(input logic a, input logic b,
                                                  input logic [TIME_W-1:0] t);
        t_event_code ev_a;
        t_event_code ev_b;
        if (a && b) begin
            btn_rep[0] = 1'b1;
            btn_rep[1] = 1'b1;
            return EV_COMBO;
        end
        ev_a = lane_step(0, a, t, EV_A_SHORT, EV_A_LONG);
        ev_b = lane_step(1, b, t, EV_B_SHORT, EV_B_LONG);
        return (ev_b != EV_NONE) ? ev_b : ev_a;
    endfunction

    // valid stays high from one transaction to the next unless a gap is drawn
    task automatic send_poll(input logic a, input logic b, input logic [TIME_W-1:0] t,
                             input logic typed, input t_event_code typed_ev);
        t_event_code ev;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_TDATA_W - TIME_W - 2){1'b0}}, t, b, a};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        ev = classify_poll(a, b, t);
        exp_events.push_back(typed ? typed_ev : ev);
        polls_sent++;
    endtask

    task automatic wait_drained;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (exp_events.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_ms     = v;
    endtask

    // press one button, hold it through up to three polls, then let go
    task automatic run_gesture;
        logic        use_b;
        logic [31:0] lim;
        logic [31:0] dur;
        logic [31:0] t0;
        int          n_hold;
        lim   = {16'd0, limit_ms};
        use_b = 1'($urandom_range(1));
        case ($urandom_range(5))
            0:       dur = (lim == 0) ? 32'd0 : lim - 1;
            1:       dur = lim;
            2:       dur = lim + 1;
            3:       dur = 2 * lim;
            4:       dur = $urandom_range(lim / 2);
            default: dur = $urandom_range(2 * lim + 2);
        endcase
        n_hold = $urandom_range(3);
        if ($urandom_range(19) == 0)
            tcur = 32'hFFFF_FFFF - $urandom_range(2 * lim + 2);
        t0 = tcur;
        send_poll(!use_b, use_b, t0, 1'b0, EV_NONE);
        for (int i = 1; i <= n_hold; i++) begin
            if ($urandom_range(9) == 0)
                send_poll(1'b1, 1'b1, t0 + dur * i / (n_hold + 1), 1'b0, EV_NONE);
            else
                send_poll(!use_b, use_b, t0 + dur * i / (n_hold + 1), 1'b0, EV_NONE);
        end
        // sometimes the release is the other button going down
        if ($urandom_range(3) == 0)
            send_poll(use_b, !use_b, t0 + dur, 1'b0, EV_NONE);
        else
            send_poll(1'b0, 1'b0, t0 + dur, 1'b0, EV_NONE);
        tcur = t0 + dur + $urandom_range(1, 40);
    endtask

    always @(posedge i_clk) begin
        if (hold_off_seen != hold_off_reqs) begin
            hold_off_seen = hold_off_reqs;
            hold_left     = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_event_code want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (exp_events.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, got %0d",
                         $time, o_m_tdata[2:0]);
            end else begin
                want = exp_events.pop_front();
                n_checked++;
                events_seen[int'(want)]++;
                if (o_m_tdata[2:0] !== want) begin
                    n_errors++;
                    $display("%0t: event_code mismatch, expected %0d, got %0d",
                             $time, want, o_m_tdata[2:0]);
                end
            end
        end
    end

    initial begin
        int phase_end;
        limit_ms       = LONG_PRESS_RESET;
        btn_held       = '{1'b0, 1'b0};
        btn_time       = '{32'd0, 32'd0};
        btn_rep        = '{1'b0, 1'b0};
        events_seen    = '{0, 0, 0, 0, 0, 0};
        polls_sent     = 0;
        n_checked      = 0;
        n_errors       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_reqs  = 0;
        hold_off_seen  = 0;
        hold_left      = 0;
        tcur           = 32'd50;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (press_script[i])
            send_poll(press_script[i].a, press_script[i].b, press_script[i].t,
                      press_script[i].typed, press_script[i].ev);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       set_limit(16'd0);
                1:       set_limit(16'd1);
                2:       set_limit(16'hFFFF);
                3:       set_limit(16'($urandom_range(2, 200)));
                4:       set_limit(16'd1000);
                5:       set_limit(16'($urandom_range(16'hFFFF)));
                6:       set_limit(16'd50);
                default: set_limit(16'd300);
            endcase
            // idle mix: none, sender gaps, receiver stalls, both
            send_idle_pct  = (p % 4 == 1) ? 59 : (p % 4 == 3) ? 32 : 0;
            recv_stall_pct = (p % 4 == 2) ? 59 : (p % 4 == 3) ? 32 : 0;
            // long receiver hold-off while the sender keeps offering
            if (p == 0)
                hold_off_reqs++;
            phase_end = polls_sent + POLLS_PER_PHASE;
            while (polls_sent < phase_end) begin
                if ($urandom_range(9) < 8)
                    run_gesture();
                else
                    send_poll(1'($urandom_range(1)), 1'($urandom_range(1)),
                              $urandom_range(1) ? $urandom : tcur + $urandom_range(2000),
                              1'b0, EV_NONE);
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        $display("run covered %0d polls over %0d limit settings with mixed idling",
                 polls_sent, N_PHASES + 1);
        $display(
            "checked %0d: none %0d, a short %0d, a long %0d, b short %0d, b long %0d, combo %0d",
            n_checked, events_seen[0], events_seen[1], events_seen[2],
            events_seen[3], events_seen[4], events_seen[5]);
        if (n_errors == 0 && exp_events.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
